### hw/rtl/mbbs_pkg.sv
// Shared types and constants for the mesh bounding box and sphere block.
package mbbs_pkg;

   localparam int COORD_BITS  = 24;
   localparam int RADIUS_BITS = 25;
   localparam int AXES        = 3;

   typedef logic signed [COORD_BITS-1:0] coord_type;
   typedef logic [RADIUS_BITS-1:0]       radius_type;

endpackage

### hw/rtl/mbbs_if.sv
// Valid/ready channel interfaces for vertex words and result words.
interface mbbs_req_if;
   import mbbs_pkg::*;

   logic      valid;
   logic      ready;
   coord_type pos_x;
   coord_type pos_y;
   coord_type pos_z;
   logic      last_vertex;

   modport source (output valid, pos_x, pos_y, pos_z, last_vertex, input ready);
   modport sink   (input valid, pos_x, pos_y, pos_z, last_vertex, output ready);
endinterface

interface mbbs_rsp_if;
   import mbbs_pkg::*;

   logic       valid;
   logic       ready;
   coord_type  min_x;
   coord_type  min_y;
   coord_type  min_z;
   coord_type  max_x;
   coord_type  max_y;
   coord_type  max_z;
   coord_type  center_x;
   coord_type  center_y;
   coord_type  center_z;
   radius_type radius;

   modport source (output valid, min_x, min_y, min_z, max_x, max_y, max_z,
                   center_x, center_y, center_z, radius, input ready);
   modport sink   (input valid, min_x, min_y, min_z, max_x, max_y, max_z,
                   center_x, center_y, center_z, radius, output ready);
endinterface

### hw/rtl/mbbs_vstore.sv
// Vertex store: one write port, one read port with registered read data.
module mbbs_vstore #(
   parameter int DEPTH = 1024,
   parameter int WIDTH = 72
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

### hw/rtl/mbbs_isqrt.sv
// Iterative integer square root, one result bit per cycle.
module mbbs_isqrt #(
   parameter int IN_WIDTH = 52
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  start,
   input  logic [IN_WIDTH-1:0]   value,
   output logic                  done,
   output logic [IN_WIDTH/2-1:0] root
);

   localparam int OUT_WIDTH = IN_WIDTH / 2;
   localparam int CNT_W     = $clog2(OUT_WIDTH + 1);

   logic [IN_WIDTH-1:0]  val_ff, val_in;
   logic [OUT_WIDTH+1:0] rem_ff, rem_in;
   logic [OUT_WIDTH-1:0] root_ff, root_in;
   logic [CNT_W-1:0]     cnt_ff, cnt_in;
   logic                 busy_ff, busy_in;
   logic                 done_ff, done_in;
   logic [OUT_WIDTH+1:0] rem_shift;
   logic [OUT_WIDTH+1:0] trial;
   logic                 take;

   assign rem_shift = {rem_ff[OUT_WIDTH-1:0], val_ff[IN_WIDTH-1 -: 2]};
   assign trial     = {root_ff, 2'b01};
   assign take      = rem_shift >= trial;

   always_comb begin
      val_in  = val_ff;
      rem_in  = rem_ff;
      root_in = root_ff;
      cnt_in  = cnt_ff;
      busy_in = busy_ff;
      done_in = 1'b0;
      if (start) begin
         val_in  = value;
         rem_in  = '0;
         root_in = '0;
         cnt_in  = CNT_W'(OUT_WIDTH);
         busy_in = 1'b1;
      end else if (busy_ff) begin
         val_in  = {val_ff[IN_WIDTH-3:0], 2'b00};
         rem_in  = take ? rem_shift - trial : rem_shift;
         root_in = {root_ff[OUT_WIDTH-2:0], take};
         cnt_in  = cnt_ff - 1'b1;
         if (cnt_ff == CNT_W'(1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
      val_ff  <= val_in;
      rem_ff  <= rem_in;
      root_ff <= root_in;
   end

   assign done = done_ff;
   assign root = root_ff;

endmodule

### hw/rtl/mesh_bounding_box_and_sphere.sv
// Mesh bounding box and bounding sphere: top level with sequencer and shared squarer.
//
// Vertex words enter on req_ch (valid/ready), one per cycle while the block is
// loading. Each vertex is written to the vertex store and folds into a running
// per-axis box. A word with last_vertex set closes the mesh; req_ch.ready then
// drops until the result is registered. Vertices past MAX_VERTICES are dropped,
// but their last_vertex flag still closes the mesh.
// The close runs a center step, then a pass over the N stored vertices
// (read, then subtract, square and accumulate per axis on one shared
// 25x25 multiplier), then a square root before rsp_ch.valid is raised.
// The result word sits in an output register until rsp_ch takes it; loading of
// the next mesh goes on meanwhile, and a following close waits before writing
// its result while that register is still full.
// Reset empties the vertex count and the output register; the store is not
// cleared and needs no sweep.
module mesh_bounding_box_and_sphere #(
   parameter int MAX_VERTICES = 1024,
   parameter int COORD_WIDTH  = 24
) (
   input  logic       clock,
   input  logic       reset,
   mbbs_req_if.sink   req_ch,
   mbbs_rsp_if.source rsp_ch
);
   import mbbs_pkg::*;

   localparam int CW    = COORD_WIDTH;
   localparam int DW    = CW + 1;
   localparam int SQW   = 2 * DW;
   localparam int SUMW  = SQW + 2;
   localparam int ROOTW = SUMW / 2;
   localparam int AW    = $clog2(MAX_VERTICES);
   localparam int CNTW  = $clog2(MAX_VERTICES + 1);
   localparam int VW    = AXES * CW;

   typedef enum logic [3:0] {
      S_LOAD, S_CTR, S_READ, S_SUB, S_MUL, S_ACC, S_ROOT_GO, S_ROOT_WAIT, S_DONE
   } state_type;

   typedef enum logic [1:0] {AXIS_X, AXIS_Y, AXIS_Z} axis_type;

   state_type               state_ff, state_in;
   axis_type                axis_ff, axis_in;
   logic [CNTW-1:0]         count_ff, count_in;
   logic [AW-1:0]           idx_ff, idx_in;
   logic signed [CW-1:0]    min_ff [AXES];
   logic signed [CW-1:0]    min_in [AXES];
   logic signed [CW-1:0]    max_ff [AXES];
   logic signed [CW-1:0]    max_in [AXES];
   logic signed [CW-1:0]    ctr_ff [AXES];
   logic signed [CW-1:0]    ctr_in [AXES];
   logic signed [DW-1:0]    diff_ff, diff_in;
   logic [SQW-1:0]          sq_ff, sq_in;
   logic [SUMW-1:0]         sum_ff, sum_in;
   logic [SUMW-1:0]         best_ff, best_in;
   logic signed [CW-1:0]    omin_ff [AXES];
   logic signed [CW-1:0]    omin_in [AXES];
   logic signed [CW-1:0]    omax_ff [AXES];
   logic signed [CW-1:0]    omax_in [AXES];
   logic signed [CW-1:0]    octr_ff [AXES];
   logic signed [CW-1:0]    octr_in [AXES];
   radius_type              orad_ff, orad_in;
   logic                    rsp_valid_ff, rsp_valid_in;

   logic signed [CW-1:0]    vin [AXES];
   logic signed [DW-1:0]    mid_sum [AXES];
   logic                    accept;
   logic                    store_ok;
   logic [VW-1:0]           rd_data;
   logic signed [CW-1:0]    rd_coord;
   logic signed [CW-1:0]    ctr_sel;
   logic signed [SQW-1:0]   prod;
   logic [SUMW-1:0]         total;
   logic                    sqrt_start;
   logic                    sqrt_done;
   logic [ROOTW-1:0]        sqrt_root;

   assign vin[0] = req_ch.pos_x[CW-1:0];
   assign vin[1] = req_ch.pos_y[CW-1:0];
   assign vin[2] = req_ch.pos_z[CW-1:0];

   assign req_ch.ready = (state_ff == S_LOAD);
   assign accept       = req_ch.valid && req_ch.ready;
   assign store_ok     = count_ff < CNTW'(MAX_VERTICES);

   mbbs_vstore #(
      .DEPTH (MAX_VERTICES),
      .WIDTH (VW)
   ) u_vstore (
      .clock   (clock),
      .wr_en   (accept && store_ok),
      .wr_addr (count_ff[AW-1:0]),
      .wr_data ({vin[2], vin[1], vin[0]}),
      .rd_en   (state_ff == S_READ),
      .rd_addr (idx_ff),
      .rd_data (rd_data)
   );

   mbbs_isqrt #(
      .IN_WIDTH (SUMW)
   ) u_isqrt (
      .clock (clock),
      .reset (reset),
      .start (sqrt_start),
      .value (best_ff),
      .done  (sqrt_done),
      .root  (sqrt_root)
   );

   always_comb begin
      case (axis_ff)
         AXIS_X: begin
            rd_coord = rd_data[CW-1:0];
            ctr_sel  = ctr_ff[0];
         end
         AXIS_Y: begin
            rd_coord = rd_data[2*CW-1:CW];
            ctr_sel  = ctr_ff[1];
         end
         AXIS_Z: begin
            rd_coord = rd_data[3*CW-1:2*CW];
            ctr_sel  = ctr_ff[2];
         end
         default: begin
            rd_coord = '0;
            ctr_sel  = '0;
         end
      endcase
   end

   assign prod  = diff_ff * diff_ff;
   assign total = sum_ff + SUMW'(sq_ff);

   always_comb begin
      for (int a = 0; a < AXES; a++) begin
         mid_sum[a] = DW'(min_ff[a]) + DW'(max_ff[a]);
      end
   end

   always_comb begin
      state_in     = state_ff;
      axis_in      = axis_ff;
      count_in     = count_ff;
      idx_in       = idx_ff;
      min_in       = min_ff;
      max_in       = max_ff;
      ctr_in       = ctr_ff;
      diff_in      = diff_ff;
      sq_in        = sq_ff;
      sum_in       = sum_ff;
      best_in      = best_ff;
      omin_in      = omin_ff;
      omax_in      = omax_ff;
      octr_in      = octr_ff;
      orad_in      = orad_ff;
      rsp_valid_in = rsp_valid_ff;
      sqrt_start   = 1'b0;

      if (rsp_ch.ready) begin
         rsp_valid_in = 1'b0;
      end

      case (state_ff)
         S_LOAD: begin
            if (accept) begin
               if (store_ok) begin
                  for (int a = 0; a < AXES; a++) begin
                     if (count_ff == '0) begin
                        min_in[a] = vin[a];
                        max_in[a] = vin[a];
                     end else begin
                        if (vin[a] < min_ff[a]) min_in[a] = vin[a];
                        if (vin[a] > max_ff[a]) max_in[a] = vin[a];
                     end
                  end
                  count_in = count_ff + 1'b1;
               end
               if (req_ch.last_vertex) begin
                  state_in = S_CTR;
               end
            end
         end
         S_CTR: begin
            for (int a = 0; a < AXES; a++) begin
               ctr_in[a] = mid_sum[a][DW-1:1];
            end
            best_in  = '0;
            idx_in   = '0;
            state_in = S_READ;
         end
         S_READ: begin
            axis_in  = AXIS_X;
            sum_in   = '0;
            state_in = S_SUB;
         end
         S_SUB: begin
            diff_in  = DW'(rd_coord) - DW'(ctr_sel);
            state_in = S_MUL;
         end
         S_MUL: begin
            sq_in    = prod;
            state_in = S_ACC;
         end
         S_ACC: begin
            case (axis_ff)
               AXIS_X: begin
                  sum_in   = total;
                  axis_in  = AXIS_Y;
                  state_in = S_SUB;
               end
               AXIS_Y: begin
                  sum_in   = total;
                  axis_in  = AXIS_Z;
                  state_in = S_SUB;
               end
               default: begin
                  if (total > best_ff) begin
                     best_in = total;
                  end
                  if (CNTW'(idx_ff) == count_ff - CNTW'(1)) begin
                     state_in = S_ROOT_GO;
                  end else begin
                     idx_in   = idx_ff + 1'b1;
                     state_in = S_READ;
                  end
               end
            endcase
         end
         S_ROOT_GO: begin
            sqrt_start = 1'b1;
            state_in   = S_ROOT_WAIT;
         end
         S_ROOT_WAIT: begin
            if (sqrt_done) begin
               state_in = S_DONE;
            end
         end
         S_DONE: begin
            if (!rsp_valid_ff || rsp_ch.ready) begin
               omin_in      = min_ff;
               omax_in      = max_ff;
               octr_in      = ctr_ff;
               orad_in      = RADIUS_BITS'(sqrt_root);
               rsp_valid_in = 1'b1;
               count_in     = '0;
               best_in      = '0;
               state_in     = S_LOAD;
            end
         end
         default: begin
            state_in = S_LOAD;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_LOAD;
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      axis_ff <= axis_in;
      idx_ff  <= idx_in;
      min_ff  <= min_in;
      max_ff  <= max_in;
      ctr_ff  <= ctr_in;
      diff_ff <= diff_in;
      sq_ff   <= sq_in;
      sum_ff  <= sum_in;
      best_ff <= best_in;
      omin_ff <= omin_in;
      omax_ff <= omax_in;
      octr_ff <= octr_in;
      orad_ff <= orad_in;
   end

   assign rsp_ch.valid    = rsp_valid_ff;
   assign rsp_ch.min_x    = COORD_BITS'(omin_ff[0]);
   assign rsp_ch.min_y    = COORD_BITS'(omin_ff[1]);
   assign rsp_ch.min_z    = COORD_BITS'(omin_ff[2]);
   assign rsp_ch.max_x    = COORD_BITS'(omax_ff[0]);
   assign rsp_ch.max_y    = COORD_BITS'(omax_ff[1]);
   assign rsp_ch.max_z    = COORD_BITS'(omax_ff[2]);
   assign rsp_ch.center_x = COORD_BITS'(octr_ff[0]);
   assign rsp_ch.center_y = COORD_BITS'(octr_ff[1]);
   assign rsp_ch.center_z = COORD_BITS'(octr_ff[2]);
   assign rsp_ch.radius   = orad_ff;

`ifndef SYNTH
   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CNTW'(MAX_VERTICES))
      else $error("vertex count beyond store depth");

   a_close_stalls: assert property (@(posedge clock) disable iff (reset)
      (req_ch.valid && req_ch.ready && req_ch.last_vertex) |=> !req_ch.ready)
      else $error("input still ready after closing word");

   a_center_in_box: assert property (@(posedge clock) disable iff (reset)
      rsp_ch.valid |-> (rsp_ch.center_x >= rsp_ch.min_x && rsp_ch.center_x <= rsp_ch.max_x
                     && rsp_ch.center_y >= rsp_ch.min_y && rsp_ch.center_y <= rsp_ch.max_y
                     && rsp_ch.center_z >= rsp_ch.min_z && rsp_ch.center_z <= rsp_ch.max_z))
      else $error("center outside box");

   a_root_done_state: assert property (@(posedge clock) disable iff (reset)
      sqrt_done |-> state_ff == S_ROOT_WAIT)
      else $error("square root finished outside wait state");
`endif

endmodule
